>>> rtl/fexp_pkg.sv
// Package: constants and tables for the floating-point exp unit.
`default_nettype none
package fexp_pkg;
    localparam int XW = 25;
    localparam int FW = 26;
    localparam int YW = 18;
    localparam logic [FW-1:0] ONE_Q25 = 26'h2000000;
    localparam logic [FW-1:0] ALL_ONES = 26'h3FFFFFF;
    localparam logic [XW-1:0] INF_WORD = {2'b10, 1'b0, 8'hFF, 14'h0};
    localparam logic [7:0] EXP_HI = 8'd133;
    localparam logic [7:0] EXP_LO = 8'd104;
    localparam logic [7:0] EXP_BIAS = 8'd127;

    typedef logic [FW-1:0] fx_t;

    function automatic logic [11:0] kinv_hi(input logic [4:0] i);
        logic [11:0] t [32];
        t = '{12'h008, 12'h064, 12'h0C1, 12'h11D, 12'h179, 12'h1D6, 12'h232, 12'h28E,
              12'h2EB, 12'h347, 12'h3A3, 12'h400, 12'h45C, 12'h4B8, 12'h515, 12'h571,
              12'h5CD, 12'h62A, 12'h686, 12'h6E2, 12'h73F, 12'h79B, 12'h7F7, 12'h854,
              12'h8B0, 12'h90C, 12'h969, 12'h9C5, 12'hA21, 12'hA7E, 12'hADA, 12'hB36};
        return t[i];
    endfunction

    function automatic logic [6:0] kinv_lo(input logic [4:0] i);
        logic [6:0] t [32];
        t = '{7'h00, 7'h03, 7'h06, 7'h09, 7'h0C, 7'h0E, 7'h11, 7'h14,
              7'h17, 7'h1A, 7'h1D, 7'h20, 7'h23, 7'h26, 7'h28, 7'h2B,
              7'h2E, 7'h31, 7'h34, 7'h37, 7'h3A, 7'h3D, 7'h3F, 7'h42,
              7'h45, 7'h48, 7'h4B, 7'h4E, 7'h51, 7'h54, 7'h57, 7'h59};
        return t[i];
    endfunction

    // only the low 18 bits of K*ln2 matter
    function automatic logic [YW-1:0] kln_hi(input logic [4:0] i);
        logic [25:0] t [32];
        t = '{26'h0000000, 26'h0162E43, 26'h02C5C86, 26'h0428AC9, 26'h058B90C,
              26'h06EE74F, 26'h0851592, 26'h09B43D5, 26'h0B17218, 26'h0C7A05B,
              26'h0DDCE9E, 26'h0F3FCE1, 26'h10A2B24, 26'h1205967, 26'h13687AA,
              26'h14CB5ED, 26'h162E430, 26'h1791273, 26'h18F40B6, 26'h1A56EF9,
              26'h1BB9D3C, 26'h1D1CB7F, 26'h1E7F9C2, 26'h1FE2805, 26'h2145648,
              26'h22A848B, 26'h240B2CE, 26'h256E111, 26'h26D0F54, 26'h2833D97,
              26'h2996BDA, 26'h2AF9A1D};
        return t[i][YW-1:0];
    endfunction

    function automatic logic [YW-1:0] kln_lo(input logic [2:0] i);
        logic [23:0] t [8];
        t = '{24'h000000, 24'h02C5C8, 24'h058B91, 24'h085159,
              24'h0B1721, 24'h0DDCEA, 24'h10A2B2, 24'h13687B};
        return t[i][YW-1:0];
    endfunction

    // exp of Y bit weight, 1Q23 widened to 1Q25 (masked to 26 bits)
    function automatic fx_t ybit_exp(input logic [4:0] i);
        logic [23:0] t [YW];
        logic [25:0] w;
        t = '{24'h800020, 24'h800040, 24'h800080, 24'h800100, 24'h800200, 24'h800400,
              24'h800800, 24'h801001, 24'h802004, 24'h804010, 24'h808040, 24'h810101,
              24'h820405, 24'h84102B, 24'h88415B, 24'h910B02, 24'hA45AF2, 24'h4DA2CC};
        w = {t[i], 2'b00};
        return w;
    endfunction

    // truncated 1Q25 product
    function automatic fx_t mul_q25(input fx_t a, input fx_t b);
        logic [2*FW-1:0] p;
        p = {{FW{1'b0}}, a} * {{FW{1'b0}}, b};
        return p[2*FW-2:FW-1];
    endfunction
endpackage
`default_nettype wire

>>> rtl/float_exponential_unit_top.sv
// Top level: pipelined exp(x) on a 25-bit float word.
// Throughput: one request per cycle while the result is not stalled by m_ready;
// each of 5 product-tree levels is a stage.
// A stall holds every stage in place; nothing is dropped or repeated.
// aresetn (synchronous, active low) clears all valid bits; data is not reset.
// Stages: decode/shift, K tables, Y, tree levels 1..5, pack.
`default_nettype none
module float_exponential_unit_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [24:0] s_x_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [24:0]      m_result_word,
    output logic [25:0]      m_fixed_mantissa,
    output logic signed [7:0] m_scale_power
);
    localparam int NS = 9;
    logic [NS-1:0] v_reg;
    logic          adv;
    assign adv     = !v_reg[NS-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-2:0], s_valid};
        end
    end

    // stage 1: classify and shift to fixed point
    logic [7:0]  e_in;
    logic [24:0] ux_next;
    logic [18:0] base;
    assign e_in = s_x_word[21:14];
    assign base = {1'b1, s_x_word[13:0], 4'b0};
    always_comb begin
        if (e_in >= fexp_pkg::EXP_BIAS) begin
            ux_next = {6'b0, base} << 3'(e_in - fexp_pkg::EXP_BIAS);
        end else begin
            ux_next = {6'b0, base} >> 5'(fexp_pkg::EXP_BIAS - e_in);
        end
    end
    logic [24:0] ux1_reg;
    logic        neg1_reg, spec1_reg;
    logic [25:0] sfx1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            ux1_reg   <= ux_next;
            neg1_reg  <= s_x_word[22];
            spec1_reg <= (e_in > fexp_pkg::EXP_HI) || (e_in < fexp_pkg::EXP_LO);
            if (e_in > fexp_pkg::EXP_HI) begin
                sfx1_reg <= s_x_word[22] ? '0 : fexp_pkg::ALL_ONES;
            end else begin
                sfx1_reg <= fexp_pkg::ONE_Q25;
            end
        end
    end

    // stage 2: K from the 1/ln2 tables
    logic [12:0] ksum;
    assign ksum = {1'b0, fexp_pkg::kinv_hi(ux1_reg[24:20])}
                + {6'b0, fexp_pkg::kinv_lo(ux1_reg[19:15])};
    logic [7:0]  kabs2_reg;
    logic [17:0] lo2_reg;
    logic        neg2_reg, spec2_reg;
    logic [25:0] sfx2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            kabs2_reg <= ksum[11:4];
            lo2_reg   <= ux1_reg[17:0];
            neg2_reg  <= neg1_reg;
            spec2_reg <= spec1_reg;
            sfx2_reg  <= sfx1_reg;
        end
    end

    // stage 3: Y = x - K*ln2 and signed K
    logic [17:0] kl, y;
    logic [6:0]  k7;
    assign kl = fexp_pkg::kln_hi(kabs2_reg[7:3]) + fexp_pkg::kln_lo(kabs2_reg[2:0]);
    assign y  = neg2_reg ? (kl - lo2_reg) : (lo2_reg - kl);
    assign k7 = kabs2_reg[6:0];
    logic [17:0] y3_reg;
    logic [7:0]  k3_reg;
    logic        spec3_reg;
    logic [25:0] sfx3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            y3_reg    <= y;
            spec3_reg <= spec2_reg;
            sfx3_reg  <= sfx2_reg;
            if (spec2_reg) begin
                k3_reg <= '0;
            end else begin
                k3_reg <= neg2_reg ? 8'(-{1'b0, k7}) : {1'b0, k7};
            end
        end
    end

    // product tree: levels of 9,5,3,2,1 nodes
    fexp_pkg::fx_t l1_val_reg [9];
    logic [8:0]    l1_ok_reg;
    fexp_pkg::fx_t l2_val_reg [5];
    logic [4:0]    l2_ok_reg;
    fexp_pkg::fx_t l3_val_reg [3];
    logic [2:0]    l3_ok_reg;
    fexp_pkg::fx_t l4_val_reg [2];
    logic [1:0]    l4_ok_reg;
    fexp_pkg::fx_t l5_val_reg;
    logic          l5_ok_reg;
    logic [7:0]    kp_reg [5];
    logic          sp_reg [5];
    logic [25:0]   sf_reg [5];
    logic          yz_reg [5];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 9; i++) begin
                l1_ok_reg[i] <= y3_reg[2*i] | y3_reg[2*i+1];
                if (y3_reg[2*i] && y3_reg[2*i+1]) begin
                    l1_val_reg[i] <= fexp_pkg::mul_q25(fexp_pkg::ybit_exp(5'(2*i)),
                                                       fexp_pkg::ybit_exp(5'(2*i+1)));
                end else if (y3_reg[2*i]) begin
                    l1_val_reg[i] <= fexp_pkg::ybit_exp(5'(2*i));
                end else begin
                    l1_val_reg[i] <= fexp_pkg::ybit_exp(5'(2*i+1));
                end
            end
            for (int i = 0; i < 4; i++) begin
                l2_ok_reg[i] <= l1_ok_reg[2*i] | l1_ok_reg[2*i+1];
                if (l1_ok_reg[2*i] && l1_ok_reg[2*i+1]) begin
                    l2_val_reg[i] <= fexp_pkg::mul_q25(l1_val_reg[2*i], l1_val_reg[2*i+1]);
                end else if (l1_ok_reg[2*i]) begin
                    l2_val_reg[i] <= l1_val_reg[2*i];
                end else begin
                    l2_val_reg[i] <= l1_val_reg[2*i+1];
                end
            end
            l2_ok_reg[4]  <= l1_ok_reg[8];
            l2_val_reg[4] <= l1_val_reg[8];
            for (int i = 0; i < 2; i++) begin
                l3_ok_reg[i] <= l2_ok_reg[2*i] | l2_ok_reg[2*i+1];
                if (l2_ok_reg[2*i] && l2_ok_reg[2*i+1]) begin
                    l3_val_reg[i] <= fexp_pkg::mul_q25(l2_val_reg[2*i], l2_val_reg[2*i+1]);
                end else if (l2_ok_reg[2*i]) begin
                    l3_val_reg[i] <= l2_val_reg[2*i];
                end else begin
                    l3_val_reg[i] <= l2_val_reg[2*i+1];
                end
            end
            l3_ok_reg[2]  <= l2_ok_reg[4];
            l3_val_reg[2] <= l2_val_reg[4];
            l4_ok_reg[0] <= l3_ok_reg[0] | l3_ok_reg[1];
            if (l3_ok_reg[0] && l3_ok_reg[1]) begin
                l4_val_reg[0] <= fexp_pkg::mul_q25(l3_val_reg[0], l3_val_reg[1]);
            end else if (l3_ok_reg[0]) begin
                l4_val_reg[0] <= l3_val_reg[0];
            end else begin
                l4_val_reg[0] <= l3_val_reg[1];
            end
            l4_ok_reg[1]  <= l3_ok_reg[2];
            l4_val_reg[1] <= l3_val_reg[2];
            l5_ok_reg <= l4_ok_reg[0] | l4_ok_reg[1];
            if (l4_ok_reg[0] && l4_ok_reg[1]) begin
                l5_val_reg <= fexp_pkg::mul_q25(l4_val_reg[0], l4_val_reg[1]);
            end else if (l4_ok_reg[0]) begin
                l5_val_reg <= l4_val_reg[0];
            end else begin
                l5_val_reg <= l4_val_reg[1];
            end
            // side data travels with the tree
            kp_reg[0] <= k3_reg;
            sp_reg[0] <= spec3_reg;
            sf_reg[0] <= sfx3_reg;
            yz_reg[0] <= (y3_reg == '0);
            for (int i = 1; i < 5; i++) begin
                kp_reg[i] <= kp_reg[i-1];
                sp_reg[i] <= sp_reg[i-1];
                sf_reg[i] <= sf_reg[i-1];
                yz_reg[i] <= yz_reg[i-1];
            end
        end
    end

    // final stage: select, normalize and pack
    fexp_pkg::fx_t fx;
    logic [4:0]    lz;
    logic signed [10:0] ef;
    fexp_pkg::fx_t norm;
    logic [24:0]   word;
    always_comb begin
        if (sp_reg[4]) begin
            fx = sf_reg[4];
        end else if (yz_reg[4] || !l5_ok_reg) begin
            fx = fexp_pkg::ONE_Q25;
        end else begin
            fx = l5_val_reg;
        end
        lz = '0;
        for (int i = 0; i < 26; i++) begin
            if (fx[i]) begin
                lz = 5'(25 - i);
            end
        end
        ef   = 11'(signed'(kp_reg[4])) + 11'sd127 - signed'({6'b0, lz});
        norm = fx << lz;
        // fixed-point zero and all ones win over the exponent clamp
        if (fx == '0) begin
            word = '0;
        end else if (fx == fexp_pkg::ALL_ONES) begin
            word = fexp_pkg::INF_WORD;
        end else if (ef <= 0) begin
            word = '0;
        end else if (ef >= 255) begin
            word = fexp_pkg::INF_WORD;
        end else begin
            word = {2'b01, 1'b0, ef[7:0], norm[24:11]};
        end
    end

    logic [24:0] rw_reg;
    logic [25:0] fm_reg;
    logic [7:0]  sc_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            rw_reg <= word;
            fm_reg <= fx;
            sc_reg <= kp_reg[4];
        end
    end
    assign m_result_word    = rw_reg;
    assign m_fixed_mantissa = fm_reg;
    assign m_scale_power    = signed'(sc_reg);

    // checks
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_word)))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid) |-> s_ready)
        else $error("input blocked with empty output");
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_result_word[22])
        else $error("negative exp result");
endmodule
`default_nettype wire

>>> tb/testbench.sv
// Testbench for float_exponential_unit_top: directed and random requests vs. a predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [24:0] word;
        logic [25:0] fixed;
        logic [7:0]  power;
    } exp_result_t;

    // exp predictor
    function automatic exp_result_t predict_exp(input logic [24:0] x);
        logic [11:0] kinv_hi_t [32];
        logic [6:0]  kinv_lo_t [32];
        logic [25:0] kln_hi_t [32];
        logic [23:0] kln_lo_t [8];
        logic [23:0] ybit_t [18];
        logic [25:0] val [18];
        logic        ok [18];
        logic [7:0]  e;
        logic        neg;
        logic [25:0] fx;
        logic [24:0] base, ux;
        logic [12:0] ksum;
        logic [7:0]  kabs;
        logic [17:0] kl, lo, y;
        logic [51:0] p;
        logic [25:0] norm;
        int k, n, m, i, lz, be;
        exp_result_t r;
        kinv_hi_t = '{12'h008, 12'h064, 12'h0C1, 12'h11D, 12'h179, 12'h1D6, 12'h232, 12'h28E,
            12'h2EB, 12'h347, 12'h3A3, 12'h400, 12'h45C, 12'h4B8, 12'h515, 12'h571,
            12'h5CD, 12'h62A, 12'h686, 12'h6E2, 12'h73F, 12'h79B, 12'h7F7, 12'h854,
            12'h8B0, 12'h90C, 12'h969, 12'h9C5, 12'hA21, 12'hA7E, 12'hADA, 12'hB36};
        kinv_lo_t = '{7'h00, 7'h03, 7'h06, 7'h09, 7'h0C, 7'h0E, 7'h11, 7'h14,
            7'h17, 7'h1A, 7'h1D, 7'h20, 7'h23, 7'h26, 7'h28, 7'h2B,
            7'h2E, 7'h31, 7'h34, 7'h37, 7'h3A, 7'h3D, 7'h3F, 7'h42,
            7'h45, 7'h48, 7'h4B, 7'h4E, 7'h51, 7'h54, 7'h57, 7'h59};
        kln_hi_t = '{26'h0000000, 26'h0162E43, 26'h02C5C86, 26'h0428AC9, 26'h058B90C,
            26'h06EE74F, 26'h0851592, 26'h09B43D5, 26'h0B17218, 26'h0C7A05B,
            26'h0DDCE9E, 26'h0F3FCE1, 26'h10A2B24, 26'h1205967, 26'h13687AA,
            26'h14CB5ED, 26'h162E430, 26'h1791273, 26'h18F40B6, 26'h1A56EF9,
            26'h1BB9D3C, 26'h1D1CB7F, 26'h1E7F9C2, 26'h1FE2805, 26'h2145648,
            26'h22A848B, 26'h240B2CE, 26'h256E111, 26'h26D0F54, 26'h2833D97,
            26'h2996BDA, 26'h2AF9A1D};
        kln_lo_t = '{24'h000000, 24'h02C5C8, 24'h058B91, 24'h085159,
            24'h0B1721, 24'h0DDCEA, 24'h10A2B2, 24'h13687B};
        ybit_t = '{24'h800020, 24'h800040, 24'h800080, 24'h800100, 24'h800200, 24'h800400,
            24'h800800, 24'h801001, 24'h802004, 24'h804010, 24'h808040, 24'h810101,
            24'h820405, 24'h84102B, 24'h88415B, 24'h910B02, 24'hA45AF2, 24'h4DA2CC};
        e = x[21:14];
        neg = x[22];
        k = 0;
        if (e > 8'd133) begin
            fx = neg ? 26'h0 : 26'h3FFFFFF;
        end else if (e < 8'd104) begin
            fx = 26'h2000000;
        end else begin
            base = {6'b0, 1'b1, x[13:0], 4'b0};
            if (e >= 8'd127) ux = base << (e - 8'd127);
            else ux = base >> (8'd127 - e);
            ksum = {1'b0, kinv_hi_t[ux[24:20]]} + {6'b0, kinv_lo_t[ux[19:15]]};
            kabs = ksum[11:4];
            k = int'(kabs[6:0]);
            if (neg) k = -k;
            kl = kln_hi_t[kabs[7:3]][17:0] + kln_lo_t[kabs[2:0]][17:0];
            lo = ux[17:0];
            y = neg ? kl - lo : lo - kl;
            if (y == 0) begin
                fx = 26'h2000000;
            end else begin
                // pairwise product tree
                for (i = 0; i < 18; i++) begin
                    ok[i] = y[i];
                    val[i] = y[i] ? {ybit_t[i], 2'b00} : 26'h0;
                end
                n = 18;
                while (n > 1) begin
                    m = 0;
                    for (i = 0; i < n; i += 2) begin
                        if (i + 1 < n && ok[i] && ok[i+1]) begin
                            p = {26'b0, val[i]} * {26'b0, val[i+1]};
                            val[m] = p[50:25];
                            ok[m] = 1;
                        end else if (ok[i]) begin
                            val[m] = val[i];
                            ok[m] = 1;
                        end else if (i + 1 < n && ok[i+1]) begin
                            val[m] = val[i+1];
                            ok[m] = 1;
                        end else begin
                            val[m] = 0;
                            ok[m] = 0;
                        end
                        m++;
                    end
                    n = m;
                end
                fx = ok[0] ? val[0] : 26'h2000000;
            end
        end
        // normalize and clamp
        if (fx == 0) begin
            r.word = 0;
        end else if (fx == 26'h3FFFFFF) begin
            r.word = fexp_pkg::INF_WORD;
        end else begin
            lz = 0;
            while (lz < 26 && fx[25-lz] == 1'b0) lz++;
            be = k + 127 - lz;
            norm = fx << lz;
            if (be <= 0) r.word = 0;
            else if (be >= 255) r.word = fexp_pkg::INF_WORD;
            else r.word = {2'b01, 1'b0, be[7:0], norm[24:11]};
        end
        r.fixed = fx;
        r.power = k[7:0];
        return r;
    endfunction

    class exp_scoreboard;
        exp_result_t pending[$];
        int errors = 0;

        function void note_request(input logic [24:0] x);
            pending.push_back(predict_exp(x));
        endfunction

        function void check_result(input logic [24:0] w, input logic [25:0] f,
                                   input logic [7:0] p);
            exp_result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h %h %h", w, f, p);
                return;
            end
            want = pending.pop_front();
            if (want.word !== w || want.fixed !== f || want.power !== p) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: word exp %h got %h, fixed exp %h got %h,",
                              " k exp %h got %h"},
                             want.word, w, want.fixed, f, want.power, p);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [24:0] s_x_word = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [24:0] m_result_word;
    logic [25:0] m_fixed_mantissa;
    logic signed [7:0] m_scale_power;
    exp_scoreboard sb = new();
    bit          sink_busy = 1;
    int          cycles = 0;

    float_exponential_unit_top DUT (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // watchdog and result checking
    always @(posedge aclk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("status: fail");
            $finish;
        end
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_result_word, m_fixed_mantissa, m_scale_power);
        if (aresetn && s_valid && s_ready) sb.note_request(s_x_word);
    end

    // result side back-pressure
    initial begin
        int g;
        @(posedge aresetn);
        while (sink_busy) begin
            @(negedge aclk);
            m_ready <= 1;
            g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (cycles > 1200 && cycles < 1600) g = 0;
            if (g > 0) begin
                @(negedge aclk);
                m_ready <= 0;
                repeat (g - 1) @(negedge aclk);
            end
        end
    end

    // valid drops only when an idle gap follows
    task automatic send_request(input logic [24:0] x, input int gap);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_x_word <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [24:0] make_word(input logic s, input logic [7:0] e);
        return {2'($urandom), s, e, 14'($urandom)};
    endfunction

    initial begin
        int i, g, t;
        logic [7:0] e;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed corners
        send_request(25'h0, 0);
        send_request(25'h1FFFFFF, 0);
        send_request({2'b11, 1'b0, 8'd134, 14'h0}, 0);
        send_request({2'b00, 1'b1, 8'd134, 14'h3FFF}, 0);
        send_request({2'b01, 1'b0, 8'd133, 14'h3FFF}, 0);
        send_request({2'b10, 1'b1, 8'd133, 14'h3FFF}, 0);
        send_request({2'b00, 1'b0, 8'd104, 14'h0}, 0);
        send_request({2'b00, 1'b1, 8'd104, 14'h3FFF}, 0);
        send_request({2'b00, 1'b0, 8'd103, 14'h3FFF}, 0);
        send_request({2'b00, 1'b1, 8'd103, 14'h0}, 0);
        send_request({2'b00, 1'b0, 8'd127, 14'h0}, 1);
        send_request({2'b00, 1'b1, 8'd127, 14'h0}, 0);
        send_request({2'b00, 1'b0, 8'd126, 14'h0}, 0);
        send_request({2'b00, 1'b0, 8'd132, 14'h2000}, 0);
        send_request({2'b00, 1'b1, 8'd132, 14'h2000}, 0);
        send_request({2'b00, 1'b0, 8'd130, 14'h1800}, 3);
        send_request({2'b00, 1'b1, 8'd133, 14'h0}, 0);
        send_request({2'b00, 1'b0, 8'd255, 14'h0}, 0);
        send_request({2'b00, 1'b1, 8'd0, 14'h0}, 0);
        // random requests, mostly in the computed exponent range
        for (i = 0; i < 750; i++) begin
            t = $urandom_range(0, 9);
            if (t < 8) e = 8'($urandom_range(104, 133));
            else if (t == 8) e = 8'($urandom_range(134, 255));
            else e = 8'($urandom_range(0, 103));
            g = (i > 300 && i < 450) ? 0 : pick_gap();
            send_request(make_word(1'($urandom), e), g);
        end
        s_valid <= 0;
        // drain
        t = 0;
        while (sb.pending.size() != 0 && t < 5000) begin
            @(posedge aclk);
            t++;
        end
        sink_busy = 0;
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
rtl/fexp_pkg.sv
rtl/float_exponential_unit_top.sv
tb/testbench.sv
